>>> hdl/sard_pkg.sv
package sard_pkg;

    localparam int MaxLength   = 4096;
    localparam int AngleIters  = 20;
    localparam int HalfPiQ14   = 25736;
    localparam int CntW        = 13;
    localparam int SumW        = 48;
    localparam int QueueDepth  = 4;

    // one classified element handed from the front to the back
    typedef struct packed {
        logic [31:0] base_sample;
        logic [31:0] price_step;
        logic [15:0] series_id;
        logic        last;
    } t_elem;

    typedef struct packed {
        logic [15:0] rms_distance;
        logic [15:0] result_series;
        logic        kept;
        logic        too_long;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_ACCUM,
        ST_DIVIDE,
        ST_SQRT,
        ST_EMIT
    } t_state;

    function automatic logic [21:0] angle_tab(input logic [4:0] i);
        logic [21:0] v;
        unique case (i)
            5'd0:  v = 22'd823550;
            5'd1:  v = 22'd486170;
            5'd2:  v = 22'd256879;
            5'd3:  v = 22'd130396;
            5'd4:  v = 22'd65451;
            5'd5:  v = 22'd32757;
            5'd6:  v = 22'd16383;
            5'd7:  v = 22'd8192;
            5'd8:  v = 22'd4096;
            5'd9:  v = 22'd2048;
            5'd10: v = 22'd1024;
            5'd11: v = 22'd512;
            5'd12: v = 22'd256;
            5'd13: v = 22'd128;
            5'd14: v = 22'd64;
            5'd15: v = 22'd32;
            5'd16: v = 22'd16;
            5'd17: v = 22'd8;
            5'd18: v = 22'd4;
            5'd19: v = 22'd2;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/slope_angle_rms_distance_unit.sv
// Angle RMS distance between a reference slope series and a price-step series.
// Each input transfer holds one sample pair; the transfer with tlast closes the
// series and yields one result transfer. Each element passes through a fetch,
// the shared 20-step arctangent loop and an accumulate step; a closing element
// then goes through the bit-serial divide, the square root and the result
// transfer, which waits for the receiver. A 4-entry queue sits between input
// and the arithmetic engine.
module slope_angle_rms_distance_unit
    import sard_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // base_sample, price_step, series_id
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // rms_distance, result_series
    output logic [1:0]  m_axis_tuser   // kept, too_long
);
    t_elem   in_elem, q_elem;
    t_result res;
    logic    q_full, q_empty, q_pop;

    always_comb begin
        in_elem.base_sample = s_axis_tdata[31:0];
        in_elem.price_step  = s_axis_tdata[63:32];
        in_elem.series_id   = s_axis_tdata[79:64];
        in_elem.last        = s_axis_tlast;
    end

    assign s_axis_tready = !q_full;

    sard_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push (s_axis_tvalid), .i_data(in_elem), .o_full(q_full),
        .i_pop  (q_pop), .o_empty(q_empty), .o_data(q_elem)
    );

    sard_engine u_engine (
        .i_clk, .i_rst_n,
        .i_empty(q_empty), .i_data(q_elem), .o_pop(q_pop),
        .o_valid(m_axis_tvalid), .o_result(res), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {res.result_series, res.rms_distance};
    assign m_axis_tuser = {res.too_long, res.kept};
endmodule

>>> hdl/sard_queue.sv
module sard_queue
    import sard_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_elem i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_elem o_data
);
    localparam int AW = $clog2(QueueDepth);

    t_elem          r_mem [QueueDepth];
    logic [AW:0]    r_wr, n_wr, r_rd, n_rd;

    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_empty = (r_wr == r_rd);
    assign o_data  = r_mem[r_rd[AW-1:0]];
    assign n_wr    = r_wr + (AW+1)'(i_push && !o_full);
    assign n_rd    = r_rd + (AW+1)'(i_pop && !o_empty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
        if (i_push && !o_full) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end
endmodule

>>> hdl/sard_engine.sv
module sard_engine
    import sard_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_elem   i_data,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);
    t_state r_state, n_state;
    logic signed [49:0] r_xa, r_ya, r_xb, r_yb;
    logic signed [23:0] r_za, r_zb;
    logic [4:0]         r_it;
    logic               r_nega, r_negb, r_zeroa, r_zerob;
    logic [15:0]        r_id;
    logic               r_last;
    logic [SumW-1:0]    r_sum, r_rem;
    logic [CntW-1:0]    r_cnt;
    logic               r_ovf;
    logic [5:0]         r_step;
    logic [SumW-1:0]    r_quo;
    logic [SumW-1:0]    r_sv, r_res, r_bit;
    t_result            r_out;

    logic [31:0] mag_a, mag_b;
    logic [15:0] ang_a, ang_b;
    logic signed [17:0] diff;
    logic [16:0] absd;
    logic [SumW:0] trial;
    logic [SumW-1:0] rb;

    assign mag_a = i_data.base_sample[31] ? (~i_data.base_sample + 32'd1)
                                          : i_data.base_sample;
    assign mag_b = i_data.price_step[31] ? (~i_data.price_step + 32'd1)
                                         : i_data.price_step;

    function automatic logic [15:0] round_angle(input logic signed [23:0] z);
        logic [17:0] r;
        r = (z < 0) ? 18'd0 : 18'((24'(z) + 24'd32) >> 6);
        if (r > 18'(HalfPiQ14)) r = 18'(HalfPiQ14);
        return r[15:0];
    endfunction

    always_comb begin
        ang_a = r_zeroa ? 16'd0 : round_angle(r_za);
        ang_b = r_zerob ? 16'd0 : round_angle(r_zb);
        diff  = (r_nega ? -18'(ang_a) : 18'(ang_a)) - (r_negb ? -18'(ang_b) : 18'(ang_b));
        absd  = diff[17] ? 17'(-diff) : 17'(diff);
        trial = {1'b0, r_rem[SumW-2:0], r_sum[SumW-1 - r_step]}
              - {{(SumW-CntW+1){1'b0}}, r_cnt};
        rb    = r_res + r_bit;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (!i_empty) n_state = ST_CORDIC;
            ST_CORDIC: if (r_it == 5'(AngleIters - 1)) n_state = ST_ACCUM;
            ST_ACCUM:  n_state = r_last ? ST_DIVIDE : ST_IDLE;
            ST_DIVIDE: if (r_step == 6'(SumW - 1)) n_state = ST_SQRT;
            ST_SQRT:   if (r_bit == '0) n_state = ST_EMIT;
            ST_EMIT:   if (i_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == ST_IDLE) && !i_empty;
        o_valid  = (r_state == ST_EMIT);
        o_result = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_xa <= 50'sd1 <<< 32; r_xb <= 50'sd1 <<< 32;
                    r_ya <= $signed({2'b0, mag_a, 16'd0});
                    r_yb <= $signed({2'b0, mag_b, 16'd0});
                    r_za <= '0; r_zb <= '0; r_it <= '0;
                    r_nega <= i_data.base_sample[31];
                    r_negb <= i_data.price_step[31];
                    r_zeroa <= (mag_a == 0); r_zerob <= (mag_b == 0);
                    r_id <= i_data.series_id; r_last <= i_data.last;
                end
                ST_CORDIC: begin
                    if (r_ya >= 0) begin
                        r_xa <= r_xa + (r_ya >>> r_it); r_ya <= r_ya - (r_xa >>> r_it);
                        r_za <= r_za + 24'(angle_tab(r_it));
                    end else begin
                        r_xa <= r_xa - (r_ya >>> r_it); r_ya <= r_ya + (r_xa >>> r_it);
                        r_za <= r_za - 24'(angle_tab(r_it));
                    end
                    if (r_yb >= 0) begin
                        r_xb <= r_xb + (r_yb >>> r_it); r_yb <= r_yb - (r_xb >>> r_it);
                        r_zb <= r_zb + 24'(angle_tab(r_it));
                    end else begin
                        r_xb <= r_xb - (r_yb >>> r_it); r_yb <= r_yb + (r_xb >>> r_it);
                        r_zb <= r_zb - 24'(angle_tab(r_it));
                    end
                    r_it <= r_it + 5'd1;
                end
                ST_ACCUM: begin
                    if (r_cnt < CntW'(MaxLength)) begin
                        r_sum <= r_sum + SumW'(absd) * SumW'(absd);
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    r_step <= '0;
                    r_rem  <= '0;
                end
                ST_DIVIDE: begin
                    // restoring division, one quotient bit per cycle
                    if (!trial[SumW]) begin
                        r_rem <= trial[SumW-1:0];
                        r_quo <= {r_quo[SumW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[SumW-2:0], r_sum[SumW-1 - r_step]};
                        r_quo <= {r_quo[SumW-2:0], 1'b0};
                    end
                    r_step <= r_step + 6'd1;
                    r_res  <= '0;
                    r_bit  <= SumW'(1) << (SumW - 2);
                end
                ST_SQRT: begin
                    if (r_step == 6'(SumW)) begin
                        r_sv   <= r_quo;
                        r_step <= '0;
                    end else if (r_bit != '0) begin
                        if (r_sv >= rb) begin
                            r_sv  <= r_sv - rb;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                    if (n_state == ST_EMIT) begin
                        r_out.rms_distance  <= r_res[15:0];
                        r_out.result_series <= r_id;
                        r_out.kept          <= (r_res[15:0] != 0);
                        r_out.too_long      <= r_ovf;
                        r_sum <= '0; r_cnt <= '0; r_ovf <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> hdl/sard_checker.sv
module sard_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    a_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[15:0] != 16'd0)))
        else $error("kept flag mismatch");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] <= 16'd51472))
        else $error("distance out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("back-to-back result");
endmodule

bind slope_angle_rms_distance_unit sard_checker u_checker (.*);

>>> tb/sv/rms_distance_checker.sv
module rms_distance_checker
    import sard_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    output int          o_fail_count,
    output int          o_pending
);

    localparam longint AtanStep [AngleIters] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    t_result      series_results[$];
    logic [47:0]  sum_sq;
    int unsigned  elem_cnt;
    bit           overflowed;

    function automatic longint angle_q14(input logic [31:0] sample);
        logic [31:0] mag;
        longint x, y, z, r, xs, ys;
        mag = sample[31] ? -sample : sample;
        if (mag == 0) return 0;
        x = longint'(1) <<< 32;
        y = longint'({32'd0, mag}) <<< 16;
        z = 0;
        for (int i = 0; i < AngleIters; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += AtanStep[i];
            end else begin
                x = x - ys; y = y + xs; z -= AtanStep[i];
            end
        end
        r = (z >= 0) ? ((z + 32) >>> 6) : 0;
        if (r > HalfPiQ14) r = HalfPiQ14;
        return sample[31] ? -r : r;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b; res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    assign o_pending = series_results.size();

    always @(posedge i_clk) begin
        longint d;
        logic [63:0] mean, root;
        t_result r, got;
        if (!i_rst_n) begin
            sum_sq = '0;
            elem_cnt = 0;
            overflowed = 0;
            o_fail_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (elem_cnt < MaxLength) begin
                    d = angle_q14(s_axis_tdata[31:0]) - angle_q14(s_axis_tdata[63:32]);
                    if (d < 0) d = -d;
                    sum_sq = sum_sq + 48'(d * d);
                    elem_cnt++;
                end else begin
                    overflowed = 1;
                end
                if (s_axis_tlast) begin
                    mean = {16'd0, sum_sq} / elem_cnt;
                    root = isqrt(mean);
                    r.rms_distance  = root[15:0];
                    r.result_series = s_axis_tdata[79:64];
                    r.kept          = root[15:0] != 0;
                    r.too_long      = overflowed;
                    series_results = {series_results, r};
                    sum_sq = '0;
                    elem_cnt = 0;
                    overflowed = 0;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16],
                       m_axis_tuser[0], m_axis_tuser[1]};
                if (series_results.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected result transfer: %h", got);
                end else begin
                    r = series_results.pop_front();
                    if (got !== r) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display({"mismatch: rms exp %0d got %0d, id exp %0d got %0d, ",
                                      "kept exp %0b got %0b, too_long exp %0b got %0b"},
                                     r.rms_distance, got.rms_distance,
                                     r.result_series, got.result_series,
                                     r.kept, got.kept, r.too_long, got.too_long);
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    import sard_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;  // base_sample, price_step, series_id
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;       // rms_distance, result_series
    logic [1:0]  m_axis_tuser;       // kept, too_long
    int          fail_count;
    int          pending;
    bit          sending_done = 0;

    always #5 i_clk = ~i_clk;

    slope_angle_rms_distance_unit DUT (.*);

    rms_distance_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .m_axis_tuser, .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            4: return $signed($urandom_range(0, 1023)) - 512;
            5: return $signed($urandom_range(0, 32'h3ffff)) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    // one transfer, with an optional random gap in front
    task automatic send_pair(input logic [31:0] b, input logic [31:0] p,
                             input logic [15:0] id, input logic lst);
        if ($urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {id, p, b};
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_series(input int len, input bit same);
        logic [15:0] id;
        logic [31:0] b, p;
        id = $urandom;
        for (int i = 0; i < len; i++) begin
            b = pick_sample();
            p = same ? b : pick_sample();
            send_pair(b, p, id, i == len - 1);
        end
    endtask

    // receiver stalls in a pattern of its own
    always @(posedge i_clk) begin
        int phase;
        phase = ($time / 10) % 64;
        if (phase < 20) m_axis_tready <= 1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, single element, zero distance, sign pairs
        send_pair(32'h8000_0000, 32'h7fff_ffff, 16'hffff, 1);
        send_pair(32'h7fff_ffff, 32'h8000_0000, 16'h0000, 1);
        send_pair(32'd0, 32'd0, 16'h1234, 1);
        send_pair(32'h0001_0000, 32'h0001_0000, 16'h5555, 0);
        send_pair(32'hffff_ffff, 32'h0000_0001, 16'haaaa, 1);
        send_pair(32'd1, 32'hffff_0000, 16'h00ff, 0);
        send_pair(32'h0003_0000, 32'd0, 16'h00ff, 0);
        send_pair(32'h8000_0001, 32'h7fff_fffe, 16'hff00, 1);
        send_series(4, 1);
        for (int n = 0; n < 110; n++)
            send_series($urandom_range(1, 8), $urandom_range(0, 9) == 0);
        s_axis_tvalid <= 0;
        s_axis_tlast  <= 0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        sending_done = 1;
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5000000;
        if (!sending_done) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
